// ===== hw/rtl/rvdec_pkg.sv =====
// rvdec_pkg: shared types and constants for the rv64i instruction decoder
// opcode and funct codes, operation numbers and the decoded result record
// no dependencies

package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned OpWidth    = 6;
  localparam int unsigned RegWidth   = 5;
  localparam int unsigned ImmWidth   = 32;

  // major opcodes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_OP32     = 7'h3B;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  localparam logic [6:0] F7_BASE  = 7'b0000000;
  localparam logic [6:0] F7_ALT   = 7'b0100000;
  localparam logic [5:0] HI6_BASE = 6'b000000;
  localparam logic [5:0] HI6_SRA  = 6'b010000;

  // funct3 codes
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  typedef enum logic [OpWidth-1:0] {
    OP_LB     = 6'd0,  OP_LH    = 6'd1,  OP_LW    = 6'd2,  OP_LBU   = 6'd3,
    OP_LHU    = 6'd4,  OP_LWU   = 6'd5,  OP_LD    = 6'd6,  OP_FENCE = 6'd7,
    OP_ADDI   = 6'd8,  OP_SLTI  = 6'd9,  OP_SLTIU = 6'd10, OP_XORI  = 6'd11,
    OP_ORI    = 6'd12, OP_ANDI  = 6'd13, OP_SLLI  = 6'd14, OP_SRLI  = 6'd15,
    OP_SRAI   = 6'd16, OP_ADDIW = 6'd17, OP_SLLIW = 6'd18, OP_SRLIW = 6'd19,
    OP_SRAIW  = 6'd20, OP_JALR  = 6'd21, OP_ECALL = 6'd22, OP_EBREAK = 6'd23,
    OP_AUIPC  = 6'd24, OP_LUI   = 6'd25, OP_SB    = 6'd26, OP_SH    = 6'd27,
    OP_SW     = 6'd28, OP_SD    = 6'd29, OP_ADD   = 6'd30, OP_SUB   = 6'd31,
    OP_SLL    = 6'd32, OP_SLT   = 6'd33, OP_SLTU  = 6'd34, OP_XOR   = 6'd35,
    OP_SRL    = 6'd36, OP_SRA   = 6'd37, OP_OR    = 6'd38, OP_AND   = 6'd39,
    OP_ADDW   = 6'd40, OP_SUBW  = 6'd41, OP_SLLW  = 6'd42, OP_SRLW  = 6'd43,
    OP_SRAW   = 6'd44, OP_BEQ   = 6'd45, OP_BNE   = 6'd46, OP_BLT   = 6'd47,
    OP_BGE    = 6'd48, OP_BLTU  = 6'd49, OP_BGEU  = 6'd50, OP_JAL   = 6'd51
  } op_e;

  typedef struct packed {
    logic                is_valid;
    op_e                 op_number;
    logic [RegWidth-1:0] dest_reg;
    logic [RegWidth-1:0] src1_reg;
    logic [RegWidth-1:0] src2_reg;
    logic [ImmWidth-1:0] immediate;
  } dec_res_t;

endpackage

// ===== hw/rtl/rvdec_decode.sv =====
// rvdec_decode: combinational rv64i decode of one instruction word
// produces the decoded result record; depends on rvdec_pkg

module rvdec_decode (
  input  logic [rvdec_pkg::InstrWidth-1:0] instr_i,
  output rvdec_pkg::dec_res_t              res_o
);
  import rvdec_pkg::*;

  logic [6:0]          opc;
  logic [2:0]          f3;
  logic [6:0]          f7;
  logic [5:0]          hi6;
  logic [4:0]          rd;
  logic [4:0]          rs1;
  logic [4:0]          rs2;
  logic [11:0]         i12;
  logic [ImmWidth-1:0] imm_i;
  logic [ImmWidth-1:0] imm_s;
  logic [ImmWidth-1:0] imm_b;
  logic [ImmWidth-1:0] imm_u;
  logic [ImmWidth-1:0] imm_j;
  logic [ImmWidth-1:0] imm_sh6;
  logic [ImmWidth-1:0] imm_sh5;
  logic [ImmWidth-1:0] imm_raw;
  dec_res_t            res;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign rs1 = instr_i[19:15];
  assign rs2 = instr_i[24:20];
  assign f7  = instr_i[31:25];
  assign hi6 = instr_i[31:26];
  assign i12 = instr_i[31:20];

  assign imm_i   = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s   = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b   = {{20{instr_i[31]}}, instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
  assign imm_u   = {instr_i[31:12], 12'h000};
  assign imm_j   = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  assign imm_sh6 = {26'd0, instr_i[25:20]};
  assign imm_sh5 = {27'd0, instr_i[24:20]};
  assign imm_raw = {20'd0, i12};

  always_comb begin
    res = '0;
    unique case (opc)
      OPC_LOAD: begin
        res.dest_reg  = rd;
        res.src1_reg  = rs1;
        res.immediate = imm_i;
        res.is_valid  = 1'b1;
        unique case (f3)
          F3_0:    res.op_number = OP_LB;
          F3_1:    res.op_number = OP_LH;
          F3_2:    res.op_number = OP_LW;
          F3_3:    res.op_number = OP_LD;
          F3_4:    res.op_number = OP_LBU;
          F3_5:    res.op_number = OP_LHU;
          F3_6:    res.op_number = OP_LWU;
          default: res.is_valid  = 1'b0;
        endcase
      end
      OPC_MISC_MEM: begin
        res.is_valid  = (f3 == F3_0);
        res.op_number = OP_FENCE;
        res.dest_reg  = rd;
        res.src1_reg  = rs1;
        res.immediate = imm_raw;
      end
      OPC_OP_IMM: begin
        res.dest_reg  = rd;
        res.src1_reg  = rs1;
        res.immediate = imm_i;
        res.is_valid  = 1'b1;
        unique case (f3)
          F3_0: res.op_number = OP_ADDI;
          F3_2: res.op_number = OP_SLTI;
          F3_3: res.op_number = OP_SLTIU;
          F3_4: res.op_number = OP_XORI;
          F3_6: res.op_number = OP_ORI;
          F3_7: res.op_number = OP_ANDI;
          F3_1: begin
            res.op_number = OP_SLLI;
            res.immediate = imm_sh6;
            res.is_valid  = (hi6 == HI6_BASE);
          end
          default: begin
            res.op_number = (hi6 == HI6_SRA) ? OP_SRAI : OP_SRLI;
            res.immediate = imm_sh6;
            res.is_valid  = (hi6 == HI6_BASE) || (hi6 == HI6_SRA);
          end
        endcase
      end
      OPC_OP_IMM32: begin
        res.dest_reg = rd;
        res.src1_reg = rs1;
        priority if (f3 == F3_0) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_ADDIW;
          res.immediate = imm_i;
        end else if (f3 == F3_1 && f7 == F7_BASE) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SLLIW;
          res.immediate = imm_sh5;
        end else if (f3 == F3_5 && f7 == F7_BASE) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SRLIW;
          res.immediate = imm_sh5;
        end else if (f3 == F3_5 && f7 == F7_ALT) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SRAIW;
          res.immediate = imm_sh5;
        end else begin
          res.is_valid  = 1'b0;
        end
      end
      OPC_JALR: begin
        res.is_valid  = (f3 == F3_0);
        res.op_number = OP_JALR;
        res.dest_reg  = rd;
        res.src1_reg  = rs1;
        res.immediate = imm_i;
      end
      OPC_SYSTEM: begin
        res.is_valid  = (f3 == F3_0) && (rd == '0) && (rs1 == '0) && (i12[11:1] == '0);
        res.op_number = i12[0] ? OP_EBREAK : OP_ECALL;
        res.immediate = imm_raw;
      end
      OPC_AUIPC: begin
        res.is_valid  = 1'b1;
        res.op_number = OP_AUIPC;
        res.dest_reg  = rd;
        res.immediate = imm_u;
      end
      OPC_LUI: begin
        res.is_valid  = 1'b1;
        res.op_number = OP_LUI;
        res.dest_reg  = rd;
        res.immediate = imm_u;
      end
      OPC_STORE: begin
        res.src1_reg  = rs1;
        res.src2_reg  = rs2;
        res.immediate = imm_s;
        res.is_valid  = 1'b1;
        unique case (f3)
          F3_0:    res.op_number = OP_SB;
          F3_1:    res.op_number = OP_SH;
          F3_2:    res.op_number = OP_SW;
          F3_3:    res.op_number = OP_SD;
          default: res.is_valid  = 1'b0;
        endcase
      end
      OPC_OP: begin
        res.dest_reg = rd;
        res.src1_reg = rs1;
        res.src2_reg = rs2;
        priority if (f7 == F7_BASE) begin
          res.is_valid = 1'b1;
          unique case (f3)
            F3_0: res.op_number = OP_ADD;
            F3_1: res.op_number = OP_SLL;
            F3_2: res.op_number = OP_SLT;
            F3_3: res.op_number = OP_SLTU;
            F3_4: res.op_number = OP_XOR;
            F3_5: res.op_number = OP_SRL;
            F3_6: res.op_number = OP_OR;
            default: res.op_number = OP_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_0) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SUB;
        end else if (f7 == F7_ALT && f3 == F3_5) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SRA;
        end else begin
          res.is_valid  = 1'b0;
        end
      end
      OPC_OP32: begin
        res.dest_reg = rd;
        res.src1_reg = rs1;
        res.src2_reg = rs2;
        priority if (f7 == F7_BASE && f3 == F3_0) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_ADDW;
        end else if (f7 == F7_BASE && f3 == F3_1) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SLLW;
        end else if (f7 == F7_BASE && f3 == F3_5) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SRLW;
        end else if (f7 == F7_ALT && f3 == F3_0) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SUBW;
        end else if (f7 == F7_ALT && f3 == F3_5) begin
          res.is_valid  = 1'b1;
          res.op_number = OP_SRAW;
        end else begin
          res.is_valid  = 1'b0;
        end
      end
      OPC_BRANCH: begin
        res.src1_reg  = rs1;
        res.src2_reg  = rs2;
        res.immediate = imm_b;
        res.is_valid  = 1'b1;
        unique case (f3)
          F3_0:    res.op_number = OP_BEQ;
          F3_1:    res.op_number = OP_BNE;
          F3_4:    res.op_number = OP_BLT;
          F3_5:    res.op_number = OP_BGE;
          F3_6:    res.op_number = OP_BLTU;
          F3_7:    res.op_number = OP_BGEU;
          default: res.is_valid  = 1'b0;
        endcase
      end
      OPC_JAL: begin
        res.is_valid  = 1'b1;
        res.op_number = OP_JAL;
        res.dest_reg  = rd;
        res.immediate = imm_j;
      end
      default: res.is_valid = 1'b0;
    endcase

    // undefined encodings report all zero
    if (res.is_valid) begin
      res_o = res;
    end else begin
      res_o = '0;
    end
  end

endmodule

// ===== hw/rtl/rvdec_out_stage.sv =====
// rvdec_out_stage: result register with valid/stall handshake
// holds one decoded result until taken; depends on rvdec_pkg

module rvdec_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rvdec_pkg::dec_res_t res_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                stall_i,
  output rvdec_pkg::dec_res_t res_o
);
  import rvdec_pkg::*;

  logic     valid_q;
  logic     valid_d;
  dec_res_t res_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/rv64i_instruction_decoder.sv =====
// Decodes one RV64I instruction word per transaction into a valid flag, a dense operation
// number (LB=0 through JAL=51), rd/rs1/rs2 and the assembled immediate of the format
// (sign-extended I/S/B/J, U with low 12 bits zero, shift amount, or raw FENCE or SYSTEM field).
// An item is registered at the input, decoded combinationally and registered at the output,
// where it is held until it is taken while out_stall_i is low; with no stall one item is
// taken every cycle. While a finished result is stalled the input register can still take
// one more transaction.
// Undefined encodings return is_valid low with every other field zero.
// top level: input register, rvdec_decode, rvdec_out_stage; depends on rvdec_pkg

module rv64i_instruction_decoder (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [rvdec_pkg::InstrWidth-1:0]         instr_word_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic                                     is_valid_o,
  output logic [rvdec_pkg::OpWidth-1:0]            op_number_o,
  output logic [rvdec_pkg::RegWidth-1:0]           dest_reg_o,
  output logic [rvdec_pkg::RegWidth-1:0]           src1_reg_o,
  output logic [rvdec_pkg::RegWidth-1:0]           src2_reg_o,
  output logic signed [rvdec_pkg::ImmWidth-1:0]    immediate_o
);
  import rvdec_pkg::*;

  logic                  in_valid_q;
  logic                  in_valid_d;
  logic [InstrWidth-1:0] instr_q;
  logic                  in_ready;
  logic                  out_ready;
  dec_res_t              dec_res;
  dec_res_t              out_res;

  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;
  assign in_valid_d = in_ready ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      instr_q <= instr_word_i;
    end
  end

  rvdec_decode u_decode (
    .instr_i (instr_q),
    .res_o   (dec_res)
  );

  rvdec_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .res_i   (dec_res),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign is_valid_o  = out_res.is_valid;
  assign op_number_o = out_res.op_number;
  assign dest_reg_o  = out_res.dest_reg;
  assign src1_reg_o  = out_res.src1_reg;
  assign src2_reg_o  = out_res.src2_reg;
  assign immediate_o = $signed(out_res.immediate);

endmodule

// ===== sim/rv64i_instruction_decoder_checker.sv =====
`timescale 1ns / 1ps
// checker for the rv64i instruction decoder: watches both channels, decodes each accepted
// instruction word itself and compares every result field with the oldest expectation
// depends on rvdec_pkg for opcodes, funct codes, operation numbers and the result record

module rv64i_instruction_decoder_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [rvdec_pkg::InstrWidth-1:0] instr_word_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic                             is_valid_i,
  input  logic [rvdec_pkg::OpWidth-1:0]    op_number_i,
  input  logic [rvdec_pkg::RegWidth-1:0]   dest_reg_i,
  input  logic [rvdec_pkg::RegWidth-1:0]   src1_reg_i,
  input  logic [rvdec_pkg::RegWidth-1:0]   src2_reg_i,
  input  logic [rvdec_pkg::ImmWidth-1:0]   immediate_i,
  output int unsigned                      fail_cnt_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_cnt_o,
  output int unsigned                      defined_cnt_o
);
  import rvdec_pkg::*;

  typedef struct {
    logic [InstrWidth-1:0] word;
    dec_res_t              res;
  } decoded_t;

  decoded_t    decoded_q[$];
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked_cnt;
  int unsigned defined_cnt;

  assign fail_cnt_o    = fail_cnt;
  assign pending_o     = pending;
  assign checked_cnt_o = checked_cnt;
  assign defined_cnt_o = defined_cnt;

  initial begin
    fail_cnt    = 0;
    pending     = 0;
    checked_cnt = 0;
    defined_cnt = 0;
  end

  function automatic logic [31:0] sext12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic dec_res_t decode_rv64i(logic [31:0] w);
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [11:0] i12;
    logic [5:0]  hi6;
    dec_res_t    r;
    opc = w[6:0];
    rd  = w[11:7];
    f3  = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    f7  = w[31:25];
    i12 = w[31:20];
    hi6 = w[31:26];
    r = '0;
    case (opc)
      OPC_LOAD: begin
        r.is_valid = (f3 != F3_7);
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.immediate = sext12(i12);
        case (f3)
          F3_0: r.op_number = OP_LB;
          F3_1: r.op_number = OP_LH;
          F3_2: r.op_number = OP_LW;
          F3_3: r.op_number = OP_LD;
          F3_4: r.op_number = OP_LBU;
          F3_5: r.op_number = OP_LHU;
          F3_6: r.op_number = OP_LWU;
          default: ;
        endcase
      end
      OPC_MISC_MEM: begin
        r.is_valid = (f3 == F3_0);
        r.op_number = OP_FENCE;
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.immediate = {20'd0, i12};
      end
      OPC_OP_IMM: begin
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.immediate = sext12(i12);
        r.is_valid = 1'b1;
        case (f3)
          F3_0: r.op_number = OP_ADDI;
          F3_2: r.op_number = OP_SLTI;
          F3_3: r.op_number = OP_SLTIU;
          F3_4: r.op_number = OP_XORI;
          F3_6: r.op_number = OP_ORI;
          F3_7: r.op_number = OP_ANDI;
          F3_1: begin
            r.is_valid = (hi6 == HI6_BASE);
            r.op_number = OP_SLLI;
            r.immediate = {26'd0, i12[5:0]};
          end
          default: begin
            r.is_valid = (hi6 == HI6_BASE) || (hi6 == HI6_SRA);
            r.op_number = (hi6 == HI6_SRA) ? OP_SRAI : OP_SRLI;
            r.immediate = {26'd0, i12[5:0]};
          end
        endcase
      end
      OPC_OP_IMM32: begin
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.immediate = {27'd0, rs2};
        if (f3 == F3_0) begin
          r.is_valid = 1'b1;
          r.op_number = OP_ADDIW;
          r.immediate = sext12(i12);
        end else if (f3 == F3_1 && f7 == F7_BASE) begin
          r.is_valid = 1'b1;
          r.op_number = OP_SLLIW;
        end else if (f3 == F3_5 && f7 == F7_BASE) begin
          r.is_valid = 1'b1;
          r.op_number = OP_SRLIW;
        end else if (f3 == F3_5 && f7 == F7_ALT) begin
          r.is_valid = 1'b1;
          r.op_number = OP_SRAIW;
        end
      end
      OPC_JALR: begin
        r.is_valid = (f3 == F3_0);
        r.op_number = OP_JALR;
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.immediate = sext12(i12);
      end
      OPC_SYSTEM: begin
        r.is_valid = (f3 == F3_0) && (rd == 5'd0) && (rs1 == 5'd0) && (i12 <= 12'd1);
        r.op_number = i12[0] ? OP_EBREAK : OP_ECALL;
        r.immediate = {20'd0, i12};
      end
      OPC_AUIPC, OPC_LUI: begin
        r.is_valid = 1'b1;
        r.op_number = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
        r.dest_reg = rd;
        r.immediate = {w[31:12], 12'd0};
      end
      OPC_STORE: begin
        r.is_valid = (f3 <= F3_3);
        r.src1_reg = rs1;
        r.src2_reg = rs2;
        r.immediate = sext12({f7, rd});
        case (f3)
          F3_0: r.op_number = OP_SB;
          F3_1: r.op_number = OP_SH;
          F3_2: r.op_number = OP_SW;
          default: r.op_number = OP_SD;
        endcase
      end
      OPC_OP, OPC_OP32: begin
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.src2_reg = rs2;
        if (f7 == F7_BASE && opc == OPC_OP) begin
          r.is_valid = 1'b1;
          case (f3)
            F3_0: r.op_number = OP_ADD;
            F3_1: r.op_number = OP_SLL;
            F3_2: r.op_number = OP_SLT;
            F3_3: r.op_number = OP_SLTU;
            F3_4: r.op_number = OP_XOR;
            F3_5: r.op_number = OP_SRL;
            F3_6: r.op_number = OP_OR;
            default: r.op_number = OP_AND;
          endcase
        end else if (f7 == F7_BASE) begin
          r.is_valid = (f3 == F3_0) || (f3 == F3_1) || (f3 == F3_5);
          case (f3)
            F3_0: r.op_number = OP_ADDW;
            F3_1: r.op_number = OP_SLLW;
            default: r.op_number = OP_SRLW;
          endcase
        end else if (f7 == F7_ALT) begin
          r.is_valid = (f3 == F3_0) || (f3 == F3_5);
          if (f3 == F3_0) r.op_number = (opc == OPC_OP32) ? OP_SUBW : OP_SUB;
          else r.op_number = (opc == OPC_OP32) ? OP_SRAW : OP_SRA;
        end
      end
      OPC_BRANCH: begin
        r.is_valid = (f3 != F3_2) && (f3 != F3_3);
        r.src1_reg = rs1;
        r.src2_reg = rs2;
        r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3_0: r.op_number = OP_BEQ;
          F3_1: r.op_number = OP_BNE;
          F3_4: r.op_number = OP_BLT;
          F3_5: r.op_number = OP_BGE;
          F3_6: r.op_number = OP_BLTU;
          default: r.op_number = OP_BGEU;
        endcase
      end
      OPC_JAL: begin
        r.is_valid = 1'b1;
        r.op_number = OP_JAL;
        r.dest_reg = rd;
        r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      default: ;
    endcase
    if (!r.is_valid) r = '0;
    return r;
  endfunction

  function automatic bit field_ok(string fname, logic [31:0] word, logic [31:0] exp_v,
                                  logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: word %08h %s expected %0h actual %0h", $time, word, fname, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : compare_results
    decoded_t exp_r;
    bit       all_ok;
    if (!rst_ni) begin
      decoded_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual op %0d imm %0h", $time,
                   op_number_i, immediate_i);
          fail_cnt++;
        end else begin
          exp_r = decoded_q.pop_front();
          all_ok = field_ok("is_valid", exp_r.word, 32'(exp_r.res.is_valid), 32'(is_valid_i))
                 & field_ok("op_number", exp_r.word, 32'(exp_r.res.op_number),
                            32'(op_number_i))
                 & field_ok("dest_reg", exp_r.word, 32'(exp_r.res.dest_reg), 32'(dest_reg_i))
                 & field_ok("src1_reg", exp_r.word, 32'(exp_r.res.src1_reg), 32'(src1_reg_i))
                 & field_ok("src2_reg", exp_r.word, 32'(exp_r.res.src2_reg), 32'(src2_reg_i))
                 & field_ok("immediate", exp_r.word, exp_r.res.immediate, immediate_i);
          if (!all_ok) fail_cnt++;
          checked_cnt++;
          if (exp_r.res.is_valid) defined_cnt++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_r.word = instr_word_i;
        exp_r.res  = decode_rv64i(instr_word_i);
        decoded_q.push_back(exp_r);
      end
      pending = decoded_q.size();
    end
  end

endmodule

// ===== sim/rv64i_instruction_decoder_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the rv64i instruction decoder: clock, reset, instruction stimulus with
// random input gaps and output stalls, a watchdog and the verdict
// depends on rvdec_pkg, rv64i_instruction_decoder and rv64i_instruction_decoder_checker

module rv64i_instruction_decoder_tb;
  import rvdec_pkg::*;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned IdleLimit   = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [InstrWidth-1:0] instr_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  is_valid_o;
  logic [OpWidth-1:0]    op_number_o;
  logic [RegWidth-1:0]   dest_reg_o;
  logic [RegWidth-1:0]   src1_reg_o;
  logic [RegWidth-1:0]   src2_reg_o;
  logic signed [ImmWidth-1:0] immediate_o;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked_cnt;
  int unsigned defined_cnt;
  int unsigned idle_cycles;
  bit          gaps_en;
  bit          stalls_en;

  rv64i_instruction_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .instr_word_i (instr_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_valid_o   (is_valid_o),
    .op_number_o  (op_number_o),
    .dest_reg_o   (dest_reg_o),
    .src1_reg_o   (src1_reg_o),
    .src2_reg_o   (src2_reg_o),
    .immediate_o  (immediate_o)
  );

  rv64i_instruction_decoder_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .instr_word_i  (instr_word_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_valid_i    (is_valid_o),
    .op_number_i   (op_number_o),
    .dest_reg_i    (dest_reg_o),
    .src1_reg_i    (src1_reg_o),
    .src2_reg_i    (src2_reg_o),
    .immediate_i   (immediate_o),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_cnt_o (checked_cnt),
    .defined_cnt_o (defined_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // well-formed encoding of one operation, other fields random where the encoding allows
  function automatic logic [31:0] build_instr(op_e op);
    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    bit          set_f3;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[31:20] = '0;
      1: w[31:20] = '1;
      default: ;
    endcase
    set_f3 = 1'b1;
    f3 = F3_0;
    opc = OPC_JAL;
    case (op)
      OP_LB:     begin opc = OPC_LOAD; f3 = F3_0; end
      OP_LH:     begin opc = OPC_LOAD; f3 = F3_1; end
      OP_LW:     begin opc = OPC_LOAD; f3 = F3_2; end
      OP_LD:     begin opc = OPC_LOAD; f3 = F3_3; end
      OP_LBU:    begin opc = OPC_LOAD; f3 = F3_4; end
      OP_LHU:    begin opc = OPC_LOAD; f3 = F3_5; end
      OP_LWU:    begin opc = OPC_LOAD; f3 = F3_6; end
      OP_FENCE:  begin opc = OPC_MISC_MEM; f3 = F3_0; end
      OP_ADDI:   begin opc = OPC_OP_IMM; f3 = F3_0; end
      OP_SLTI:   begin opc = OPC_OP_IMM; f3 = F3_2; end
      OP_SLTIU:  begin opc = OPC_OP_IMM; f3 = F3_3; end
      OP_XORI:   begin opc = OPC_OP_IMM; f3 = F3_4; end
      OP_ORI:    begin opc = OPC_OP_IMM; f3 = F3_6; end
      OP_ANDI:   begin opc = OPC_OP_IMM; f3 = F3_7; end
      OP_SLLI:   begin opc = OPC_OP_IMM; f3 = F3_1; w[31:26] = HI6_BASE; end
      OP_SRLI:   begin opc = OPC_OP_IMM; f3 = F3_5; w[31:26] = HI6_BASE; end
      OP_SRAI:   begin opc = OPC_OP_IMM; f3 = F3_5; w[31:26] = HI6_SRA; end
      OP_ADDIW:  begin opc = OPC_OP_IMM32; f3 = F3_0; end
      OP_SLLIW:  begin opc = OPC_OP_IMM32; f3 = F3_1; w[31:25] = F7_BASE; end
      OP_SRLIW:  begin opc = OPC_OP_IMM32; f3 = F3_5; w[31:25] = F7_BASE; end
      OP_SRAIW:  begin opc = OPC_OP_IMM32; f3 = F3_5; w[31:25] = F7_ALT; end
      OP_JALR:   begin opc = OPC_JALR; f3 = F3_0; end
      OP_ECALL:  begin opc = OPC_SYSTEM; w[31:7] = '0; end
      OP_EBREAK: begin opc = OPC_SYSTEM; w[31:7] = '0; w[20] = 1'b1; end
      OP_AUIPC:  begin opc = OPC_AUIPC; set_f3 = 1'b0; end
      OP_LUI:    begin opc = OPC_LUI; set_f3 = 1'b0; end
      OP_SB:     begin opc = OPC_STORE; f3 = F3_0; end
      OP_SH:     begin opc = OPC_STORE; f3 = F3_1; end
      OP_SW:     begin opc = OPC_STORE; f3 = F3_2; end
      OP_SD:     begin opc = OPC_STORE; f3 = F3_3; end
      OP_ADD:    begin opc = OPC_OP; f3 = F3_0; w[31:25] = F7_BASE; end
      OP_SUB:    begin opc = OPC_OP; f3 = F3_0; w[31:25] = F7_ALT; end
      OP_SLL:    begin opc = OPC_OP; f3 = F3_1; w[31:25] = F7_BASE; end
      OP_SLT:    begin opc = OPC_OP; f3 = F3_2; w[31:25] = F7_BASE; end
      OP_SLTU:   begin opc = OPC_OP; f3 = F3_3; w[31:25] = F7_BASE; end
      OP_XOR:    begin opc = OPC_OP; f3 = F3_4; w[31:25] = F7_BASE; end
      OP_SRL:    begin opc = OPC_OP; f3 = F3_5; w[31:25] = F7_BASE; end
      OP_SRA:    begin opc = OPC_OP; f3 = F3_5; w[31:25] = F7_ALT; end
      OP_OR:     begin opc = OPC_OP; f3 = F3_6; w[31:25] = F7_BASE; end
      OP_AND:    begin opc = OPC_OP; f3 = F3_7; w[31:25] = F7_BASE; end
      OP_ADDW:   begin opc = OPC_OP32; f3 = F3_0; w[31:25] = F7_BASE; end
      OP_SUBW:   begin opc = OPC_OP32; f3 = F3_0; w[31:25] = F7_ALT; end
      OP_SLLW:   begin opc = OPC_OP32; f3 = F3_1; w[31:25] = F7_BASE; end
      OP_SRLW:   begin opc = OPC_OP32; f3 = F3_5; w[31:25] = F7_BASE; end
      OP_SRAW:   begin opc = OPC_OP32; f3 = F3_5; w[31:25] = F7_ALT; end
      OP_BEQ:    begin opc = OPC_BRANCH; f3 = F3_0; end
      OP_BNE:    begin opc = OPC_BRANCH; f3 = F3_1; end
      OP_BLT:    begin opc = OPC_BRANCH; f3 = F3_4; end
      OP_BGE:    begin opc = OPC_BRANCH; f3 = F3_5; end
      OP_BLTU:   begin opc = OPC_BRANCH; f3 = F3_6; end
      OP_BGEU:   begin opc = OPC_BRANCH; f3 = F3_7; end
      default:   set_f3 = 1'b0;
    endcase
    w[6:0] = opc;
    if (set_f3) w[14:12] = f3;
    return w;
  endfunction

  // called and left at a falling edge
  task automatic send_instr(logic [31:0] w);
    int unsigned gap;
    gap = gaps_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    instr_word_i = w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!stalls_en) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < 25);
        if (out_stall_i && $urandom_range(0, 15) == 0) begin
          repeat ($urandom_range(8, 30)) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed_q[$];
    logic [31:0] w;
    op_e         op;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    instr_word_i = '0;
    idle_cycles  = 0;
    gaps_en      = 1'b1;
    stalls_en    = 1'b1;
    directed_q = '{
      32'h0000_0000,
      32'hFFFF_FFFF,
      {12'd0, 5'd0, F3_0, 5'd0, OPC_SYSTEM},
      {12'd1, 5'd0, F3_0, 5'd0, OPC_SYSTEM},
      {12'd2, 5'd0, F3_0, 5'd0, OPC_SYSTEM},
      {12'd0, 5'd0, F3_0, 5'd1, OPC_SYSTEM},
      {12'd1, 5'd3, F3_0, 5'd0, OPC_SYSTEM},
      {12'd0, 5'd0, F3_1, 5'd0, OPC_SYSTEM},
      {12'hFFF, 5'd31, F3_0, 5'd31, OPC_MISC_MEM},
      {12'h0FF, 5'd1, F3_1, 5'd2, OPC_MISC_MEM},
      {HI6_SRA, 6'd63, 5'd31, F3_5, 5'd31, OPC_OP_IMM},
      {6'b000001, 6'd0, 5'd4, F3_1, 5'd5, OPC_OP_IMM},
      {HI6_BASE, 6'd32, 5'd1, F3_1, 5'd2, OPC_OP_IMM},
      {7'b0000001, 5'd5, 5'd6, F3_1, 5'd7, OPC_OP_IMM32},
      {F7_ALT, 5'd31, 5'd0, F3_5, 5'd0, OPC_OP_IMM32},
      {F7_ALT, 5'd31, 5'd31, F3_0, 5'd31, OPC_OP},
      {F7_ALT, 5'd1, 5'd2, F3_3, 5'd3, OPC_OP},
      {F7_BASE, 5'd1, 5'd2, F3_2, 5'd3, OPC_OP32},
      {12'h800, 5'd0, F3_0, 5'd0, OPC_OP_IMM},
      {12'h7FF, 5'd31, F3_0, 5'd31, OPC_OP_IMM},
      {12'h123, 5'd1, F3_7, 5'd2, OPC_LOAD},
      {7'h7F, 5'd1, 5'd2, F3_4, 5'd31, OPC_STORE},
      {7'h40, 5'd31, 5'd31, F3_3, 5'd0, OPC_STORE},
      {7'h00, 5'd1, 5'd2, F3_2, 5'd3, OPC_BRANCH},
      {1'b1, 6'd0, 5'd1, 5'd2, F3_0, 4'd0, 1'b0, OPC_BRANCH},
      {1'b1, 10'd0, 1'b0, 8'd0, 5'd31, OPC_JAL},
      {1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL},
      {20'hFFFFF, 5'd31, OPC_LUI}
    };
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_q[i]) send_instr(directed_q[i]);

    // first pass walks every operation in order, then random operations, some corrupted or replaced by random words
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 50 == 0) begin
        gaps_en   = ($urandom_range(0, 3) != 0);
        stalls_en = ($urandom_range(0, 3) != 0);
      end
      op = (i < 52) ? op_e'(i[5:0]) : op_e'($urandom_range(0, 51));
      w = build_instr(op);
      if (i >= 52) begin
        case ($urandom_range(0, 9))
          0: w = $urandom();
          1: w = w ^ (32'd1 << $urandom_range(0, 31));
          default: ;
        endcase
      end
      send_instr(w);
    end
    in_valid_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("decoded %0d instruction words: %0d defined, %0d undefined", checked_cnt,
             defined_cnt, checked_cnt - defined_cnt);
    $display("all operations, system, fence and shift corner cases, with input gaps and stalls");
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
